[rtl/core/esa_pkg.sv]
// esa_pkg: shared types and constants for the emitter slot allocator
// used by esa_table, esa_vol and emitter_slot_allocator; no dependencies
package esa_pkg;

   localparam int NUM_SLOTS = 32;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int PRIO_W    = 8;
   localparam int VOL_IN_W  = 8;
   localparam int VOL_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [VOL_W-1:0] VOL_MAX = 7'h7f;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_SCALE = 1'd1;

   localparam logic [5:0]       SLOT_COUNT_RESET   = 6'd32;
   localparam logic [VOL_W-1:0] VOLUME_SCALE_RESET = 7'd127;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_ALLOC,
      ST_COMMIT,
      ST_SCAN_FREE,
      ST_DONE
   } state_type;

   // write request into the slot table
   typedef struct packed {
      logic              set;
      logic              clr;
      logic              flush;
      logic [SLOT_W-1:0] idx;
      logic              important;
      logic [PRIO_W-1:0] prio;
   } tbl_wr_type;

endpackage

[rtl/core/esa_table.sv]
// esa_table: slot table with used bits, important bits and priorities
// depends on esa_pkg; one read port at a signal-chosen index, one write port
module esa_table import esa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_idx,
   input  tbl_wr_type        wr,
   output logic              rd_used,
   output logic              rd_important,
   output logic [PRIO_W-1:0] rd_prio
);

   logic [NUM_SLOTS-1:0] used_ff;
   logic [NUM_SLOTS-1:0] used_in;
   logic                 imp_ff  [NUM_SLOTS];
   logic [PRIO_W-1:0]    prio_ff [NUM_SLOTS];

   always_comb begin
      used_in = used_ff;
      if (wr.flush) begin
         used_in = '0;
      end else if (wr.set) begin
         used_in[wr.idx] = 1'b1;
      end else if (wr.clr) begin
         used_in[wr.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // important and priority are only read for used slots
   always_ff @(posedge clock) begin
      if (wr.set) begin
         imp_ff[wr.idx]  <= wr.important;
         prio_ff[wr.idx] <= wr.prio;
      end
   end

   assign rd_used      = used_ff[rd_idx];
   assign rd_important = imp_ff[rd_idx];
   assign rd_prio      = prio_ff[rd_idx];

endmodule

[rtl/core/esa_vol.sv]
// esa_vol: volume scaler, clamp to 127, multiply by scale, divide by 127
// depends on esa_pkg; product registered, division by 127 done as shift and one correction
module esa_vol import esa_pkg::*; (
   input  logic                clock,
   input  logic                load,
   input  logic [VOL_IN_W-1:0] vol,
   input  logic [VOL_W-1:0]    scale,
   output logic [VOL_W-1:0]    scaled
);

   localparam int PROD_W = 2 * VOL_W;

   logic [VOL_W-1:0]  clamped;
   logic [PROD_W-1:0] prod_ff;
   logic [VOL_W-1:0]  quot_est;
   logic [VOL_W:0]    rem_est;

   assign clamped = (vol > VOL_IN_W'(VOL_MAX)) ? VOL_MAX : vol[VOL_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PROD_W'(scale) * PROD_W'(clamped);
      end
   end

   // x = 128*q0 + lo = 127*q0 + (lo + q0), remainder estimate stays below 2*127
   assign quot_est = prod_ff[PROD_W-1:VOL_W];
   assign rem_est  = {1'b0, prod_ff[VOL_W-1:0]} + {1'b0, quot_est};
   assign scaled   = quot_est + VOL_W'(rem_est >= {1'b0, VOL_MAX});

endmodule

[rtl/core/emitter_slot_allocator.sv]
// emitter_slot_allocator: emitter slot table with priority stealing
// remove, flush and unknown commands pass decode and done before the result is registered;
// a granted allocate passes decode, the allocation scan (skipped on a cache hit), commit,
// the next-free rescan and done, a failed one decode, the scan and done; each scan ends at the live slot count
// throughput: one item at a time, the next transfer is taken once the result is registered
// reset: synchronous; slots free, cached free slot 0 valid, slot_count 32, volume_scale 127
module emitter_slot_allocator import esa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [PRIO_W-1:0]     req_priority,
   input  logic                  req_important,
   input  logic [VOL_IN_W-1:0]   req_max_volume,
   input  logic [VOL_IN_W-1:0]   req_min_volume,
   input  logic [SLOT_W-1:0]     req_slot_handle,
   input  logic                  req_handle_absent,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SLOT_W-1:0]     rsp_result_handle,
   output logic                  rsp_success,
   output logic                  rsp_evicted,
   output logic                  rsp_was_active,
   output logic [VOL_W-1:0]      rsp_scaled_max_volume,
   output logic [VOL_W-1:0]      rsp_scaled_min_volume,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [5:0]       slot_count_ff;
   logic [VOL_W-1:0] volume_scale_ff;

   cmd_type           cmd_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic              imp_ff;
   logic [SLOT_W-1:0] handle_ff;
   logic              absent_ff;

   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              evicted_ff, evicted_in;
   logic              success_ff, success_in;
   logic              active_ff, active_in;
   logic [SLOT_W-1:0] res_handle_ff, res_handle_in;
   logic [SLOT_W-1:0] cache_slot_ff, cache_slot_in;
   logic              cache_valid_ff, cache_valid_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_handle_ff;
   logic              rsp_success_ff, rsp_evicted_ff, rsp_active_ff;
   logic [VOL_W-1:0]  rsp_max_ff, rsp_min_ff;

   logic              accept;
   logic              rsp_load;
   logic [CNT_W-1:0]  live_count;
   logic              cache_hit;
   logic              scan_end;
   logic              steal_ok;
   logic              handle_ok;
   logic              vol_ok;

   logic [SLOT_W-1:0] rd_idx;
   tbl_wr_type        tbl_wr;
   logic              rd_used, rd_important;
   logic [PRIO_W-1:0] rd_prio;
   logic [VOL_W-1:0]  scaled_max, scaled_min;

   esa_table u_table (
      .clock        (clock),
      .reset        (reset),
      .rd_idx       (rd_idx),
      .wr           (tbl_wr),
      .rd_used      (rd_used),
      .rd_important (rd_important),
      .rd_prio      (rd_prio)
   );

   esa_vol u_vol_max (
      .clock  (clock),
      .load   (accept),
      .vol    (req_max_volume),
      .scale  (volume_scale_ff),
      .scaled (scaled_max)
   );

   esa_vol u_vol_min (
      .clock  (clock),
      .load   (accept),
      .vol    (req_min_volume),
      .scale  (volume_scale_ff),
      .scaled (scaled_min)
   );

   assign live_count = (slot_count_ff > 6'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
                                                       : CNT_W'(slot_count_ff);
   assign cache_hit  = cache_valid_ff && (CNT_W'(cache_slot_ff) < live_count);
   assign scan_end   = idx_ff >= live_count;
   assign steal_ok   = (rd_prio <= prio_ff) && !rd_important;
   assign handle_ok  = !absent_ff && (CNT_W'(handle_ff) < live_count);
   assign vol_ok     = success_ff && (cmd_ff == CMD_ALLOC);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (cmd_ff == CMD_ALLOC) begin
               state_in = cache_hit ? ST_COMMIT : ST_SCAN_ALLOC;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_ALLOC: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end else if (!rd_used || steal_ok) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: state_in = ST_SCAN_FREE;
         ST_SCAN_FREE: begin
            if (scan_end || !rd_used) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      rd_idx    = idx_ff[SLOT_W-1:0];
      tbl_wr    = '0;
      tbl_wr.idx       = slot_ff;
      tbl_wr.important = imp_ff;
      tbl_wr.prio      = prio_ff;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DECODE: begin
            rd_idx = handle_ff;
            if (cmd_ff == CMD_REMOVE) begin
               tbl_wr.clr = handle_ok && rd_used;
               tbl_wr.idx = handle_ff;
            end else if (cmd_ff == CMD_FLUSH) begin
               tbl_wr.flush = 1'b1;
            end
         end
         ST_COMMIT: tbl_wr.set = 1'b1;
         ST_DONE:   rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   // datapath next values
   always_comb begin
      idx_in         = idx_ff;
      slot_in        = slot_ff;
      evicted_in     = evicted_ff;
      success_in     = success_ff;
      active_in      = active_ff;
      res_handle_in  = res_handle_ff;
      cache_slot_in  = cache_slot_ff;
      cache_valid_in = cache_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in        = '0;
            slot_in       = '0;
            evicted_in    = 1'b0;
            success_in    = 1'b0;
            active_in     = 1'b0;
            res_handle_in = '0;
         end
         ST_DECODE: begin
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (cache_hit) slot_in = cache_slot_ff;
               end
               CMD_REMOVE: begin
                  res_handle_in = absent_ff ? '0 : handle_ff;
                  success_in    = handle_ok;
                  active_in     = handle_ok && rd_used;
                  if (handle_ok && rd_used) begin
                     cache_slot_in  = handle_ff;
                     cache_valid_in = 1'b1;
                  end
               end
               CMD_FLUSH: begin
                  cache_slot_in  = '0;
                  cache_valid_in = 1'b1;
               end
               default: ;
            endcase
         end
         ST_SCAN_ALLOC: begin
            if (!scan_end) begin
               if (!rd_used || steal_ok) begin
                  slot_in    = idx_ff[SLOT_W-1:0];
                  evicted_in = rd_used;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_COMMIT: begin
            idx_in        = '0;
            success_in    = 1'b1;
            res_handle_in = slot_ff;
         end
         ST_SCAN_FREE: begin
            if (scan_end) begin
               cache_slot_in  = '0;
               cache_valid_in = 1'b0;
            end else if (!rd_used) begin
               cache_slot_in  = idx_ff[SLOT_W-1:0];
               cache_valid_in = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         slot_count_ff   <= SLOT_COUNT_RESET;
         volume_scale_ff <= VOLUME_SCALE_RESET;
         cache_slot_ff   <= '0;
         cache_valid_ff  <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cache_slot_ff  <= cache_slot_in;
         cache_valid_ff <= cache_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SLOT_COUNT:   slot_count_ff   <= csr_wdata[5:0];
               CSR_VOLUME_SCALE: volume_scale_ff <= csr_wdata[VOL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_type'(req_cmd);
         prio_ff   <= req_priority;
         imp_ff    <= req_important;
         handle_ff <= req_slot_handle;
         absent_ff <= req_handle_absent;
      end
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      evicted_ff    <= evicted_in;
      success_ff    <= success_in;
      active_ff     <= active_in;
      res_handle_ff <= res_handle_in;
      if (rsp_load) begin
         rsp_handle_ff  <= res_handle_ff;
         rsp_success_ff <= success_ff;
         rsp_evicted_ff <= evicted_ff && vol_ok;
         rsp_active_ff  <= active_ff;
         rsp_max_ff     <= vol_ok ? scaled_max : '0;
         rsp_min_ff     <= vol_ok ? scaled_min : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_handle     = rsp_handle_ff;
   assign rsp_success           = rsp_success_ff;
   assign rsp_evicted           = rsp_evicted_ff;
   assign rsp_was_active        = rsp_active_ff;
   assign rsp_scaled_max_volume = rsp_max_ff;
   assign rsp_scaled_min_volume = rsp_min_ff;

endmodule

[tb/sv/esa_checker.sv]
// esa_checker: watches the request, response and csr ports of the emitter slot allocator,
// keeps its own copy of the slot table and compares every response field by field
// depends on esa_pkg
module esa_checker import esa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [PRIO_W-1:0]     req_priority,
   input  logic                  req_important,
   input  logic [VOL_IN_W-1:0]   req_max_volume,
   input  logic [VOL_IN_W-1:0]   req_min_volume,
   input  logic [SLOT_W-1:0]     req_slot_handle,
   input  logic                  req_handle_absent,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SLOT_W-1:0]     rsp_result_handle,
   input  logic                  rsp_success,
   input  logic                  rsp_evicted,
   input  logic                  rsp_was_active,
   input  logic [VOL_W-1:0]      rsp_scaled_max_volume,
   input  logic [VOL_W-1:0]      rsp_scaled_min_volume,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SLOT_W-1:0] handle;
      logic              success;
      logic              evicted;
      logic              was_active;
      logic [VOL_W-1:0]  vmax;
      logic [VOL_W-1:0]  vmin;
   } reply_type;

   logic              slot_used [NUM_SLOTS];
   logic              slot_keep [NUM_SLOTS];
   logic [PRIO_W-1:0] slot_prio [NUM_SLOTS];
   logic [SLOT_W-1:0] free_hint;
   logic              free_hint_ok;
   logic [5:0]        cfg_slots;
   logic [VOL_W-1:0]  cfg_scale;
   reply_type         owed_replies [$];

   function automatic int live_slots();
      return (cfg_slots > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_slots);
   endfunction

   function automatic logic [VOL_W-1:0] scaled_volume(logic [VOL_IN_W-1:0] v);
      int c;
      c = (v > VOL_MAX) ? int'(VOL_MAX) : int'(v);
      return VOL_W'((int'(cfg_scale) * c) / int'(VOL_MAX));
   endfunction

   // runs one command against the local slot table and returns the response it owes
   function automatic reply_type apply_slot_cmd();
      reply_type r;
      int        n;
      int        s;
      int        i;
      logic      hit;
      logic      stole;
      r = '0;
      n = live_slots();
      s = 0;
      hit = 1'b0;
      stole = 1'b0;
      case (req_cmd)
         CMD_ALLOC: begin
            if (free_hint_ok && free_hint < n) begin
               s = int'(free_hint);
               hit = 1'b1;
            end else begin
               for (i = 0; i < n && !hit; i++) begin
                  if (!slot_used[i]) begin
                     s = i;
                     hit = 1'b1;
                  end else if (slot_prio[i] <= req_priority && !slot_keep[i]) begin
                     s = i;
                     hit = 1'b1;
                     stole = 1'b1;
                  end
               end
            end
            if (hit) begin
               slot_used[s] = 1'b1;
               slot_keep[s] = req_important;
               slot_prio[s] = req_priority;
               // next free is the lowest unused slot below the live count
               free_hint_ok = 1'b0;
               free_hint = '0;
               for (i = 0; i < n && !free_hint_ok; i++) begin
                  if (!slot_used[i]) begin
                     free_hint = SLOT_W'(i);
                     free_hint_ok = 1'b1;
                  end
               end
               r.handle = SLOT_W'(s);
               r.success = 1'b1;
               r.evicted = stole;
               r.vmax = scaled_volume(req_max_volume);
               r.vmin = scaled_volume(req_min_volume);
            end
         end
         CMD_REMOVE: begin
            if (!req_handle_absent) begin
               r.handle = req_slot_handle;
               if (req_slot_handle < n) begin
                  r.success = 1'b1;
                  if (slot_used[req_slot_handle]) begin
                     r.was_active = 1'b1;
                     slot_used[req_slot_handle] = 1'b0;
                     free_hint = req_slot_handle;
                     free_hint_ok = 1'b1;
                  end
               end
            end
         end
         CMD_FLUSH: begin
            for (i = 0; i < NUM_SLOTS; i++) slot_used[i] = 1'b0;
            free_hint = '0;
            free_hint_ok = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_keep[i] = 1'b0;
            slot_prio[i] = '0;
         end
         free_hint = '0;
         free_hint_ok = 1'b1;
         cfg_slots = SLOT_COUNT_RESET;
         cfg_scale = VOLUME_SCALE_RESET;
         owed_replies.delete();
         errors = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SLOT_COUNT:   cfg_slots = csr_wdata[5:0];
               CSR_VOLUME_SCALE: cfg_scale = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               $error("response transfer with no request outstanding");
               errors++;
            end else begin
               want = owed_replies.pop_front();
               check_field("result_handle", 8'(want.handle), 8'(rsp_result_handle));
               check_field("success", 8'(want.success), 8'(rsp_success));
               check_field("evicted", 8'(want.evicted), 8'(rsp_evicted));
               check_field("was_active", 8'(want.was_active), 8'(rsp_was_active));
               check_field("scaled_max_volume", 8'(want.vmax), 8'(rsp_scaled_max_volume));
               check_field("scaled_min_volume", 8'(want.vmin), 8'(rsp_scaled_min_volume));
            end
         end
         if (req_valid && req_ready) owed_replies.push_back(apply_slot_cmd());
      end
      outstanding <= owed_replies.size();
   end

endmodule

[tb/sv/tb_emitter_slot_allocator.sv]
// tb_emitter_slot_allocator: clock, reset, request and response traffic and csr writes
// for emitter_slot_allocator; checking is done by esa_checker
// depends on esa_pkg, esa_checker and the allocator rtl
module tb_emitter_slot_allocator import esa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNKNOWN     = 2'd3;
   localparam int         IDLE_LIMIT      = 3000;
   localparam int         DRAIN_CYCLES    = 80;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam int         SEGMENTS        = 10;
   localparam int         SEGMENT_ITEMS   = 125;

   typedef struct {
      logic [1:0]          cmd;
      logic [PRIO_W-1:0]   prio;
      logic                imp;
      logic [VOL_IN_W-1:0] vmax;
      logic [VOL_IN_W-1:0] vmin;
      logic [SLOT_W-1:0]   handle;
      logic                absent;
   } req_fields_t;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_TOGGLE, RX_SPARSE, RX_HOLD} rx_mode_t;

   logic                  clock;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_cmd           = '0;
   logic [PRIO_W-1:0]     req_priority      = '0;
   logic                  req_important     = 1'b0;
   logic [VOL_IN_W-1:0]   req_max_volume    = '0;
   logic [VOL_IN_W-1:0]   req_min_volume    = '0;
   logic [SLOT_W-1:0]     req_slot_handle   = '0;
   logic                  req_handle_absent = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [SLOT_W-1:0]     rsp_result_handle;
   logic                  rsp_success;
   logic                  rsp_evicted;
   logic                  rsp_was_active;
   logic [VOL_W-1:0]      rsp_scaled_max_volume;
   logic [VOL_W-1:0]      rsp_scaled_min_volume;
   logic                  csr_we            = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index         = '0;
   logic [CSR_DATA_W-1:0] csr_wdata         = '0;
   int                    errors;
   int                    outstanding;
   int                    idle_cycles       = 0;
   int                    burst_left        = 1;
   int                    live_count        = NUM_SLOTS;

   emitter_slot_allocator i_dut (.*);

   esa_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic req_fields_t pack_req(logic [1:0] cmd, int prio, logic imp, int vmax,
                                            int vmin, int handle, logic absent);
      req_fields_t f;
      f.cmd = cmd;
      f.prio = PRIO_W'(prio);
      f.imp = imp;
      f.vmax = VOL_IN_W'(vmax);
      f.vmin = VOL_IN_W'(vmin);
      f.handle = SLOT_W'(handle);
      f.absent = absent;
      return f;
   endfunction

   function automatic req_fields_t random_req(int live);
      req_fields_t f;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) f.cmd = CMD_ALLOC;
      else if (pick < 96) f.cmd = CMD_REMOVE;
      else if (pick < 98) f.cmd = CMD_FLUSH;
      else f.cmd = CMD_UNKNOWN;
      f.prio = PRIO_W'($urandom_range(0, 255));
      f.imp = ($urandom_range(0, 3) == 0);
      f.vmax = VOL_IN_W'($urandom_range(0, 255));
      f.vmin = VOL_IN_W'($urandom_range(0, 255));
      // mostly aim removes at live slots, sometimes anywhere in the handle range
      if (live > 0 && $urandom_range(0, 4) != 0) f.handle = SLOT_W'($urandom_range(0, live - 1));
      else f.handle = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
      f.absent = ($urandom_range(0, 7) == 0);
      return f;
   endfunction

   task automatic send(req_fields_t f);
      int gap;
      req_valid <= 1'b1;
      req_cmd <= f.cmd;
      req_priority <= f.prio;
      req_important <= f.imp;
      req_max_volume <= f.vmax;
      req_min_volume <= f.vmin;
      req_slot_handle <= f.handle;
      req_handle_absent <= f.absent;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and wait until every response has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(int slots, int scale);
      settle();
      write_reg(CSR_SLOT_COUNT, slots);
      write_reg(CSR_VOLUME_SCALE, scale);
      live_count = (slots > NUM_SLOTS) ? NUM_SLOTS : slots;
   endtask

   initial begin : stimulus
      int seg_slots;
      int seg_scale;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: cache hits, volume clamps, removes, unknown command, flush
      send(pack_req(CMD_ALLOC, 0, 1'b0, 255, 0, 0, 1'b0));
      send(pack_req(CMD_ALLOC, 255, 1'b1, 127, 128, 31, 1'b0));
      send(pack_req(CMD_REMOVE, 0, 1'b0, 0, 0, 0, 1'b0));
      send(pack_req(CMD_REMOVE, 0, 1'b0, 0, 0, 0, 1'b0));
      send(pack_req(CMD_REMOVE, 255, 1'b1, 255, 255, 31, 1'b1));
      send(pack_req(CMD_UNKNOWN, 8'ha5, 1'b1, 8'h5a, 8'hff, 5'h15, 1'b1));
      send(pack_req(CMD_FLUSH, 8'h5a, 1'b0, 8'ha5, 8'h80, 5'h0a, 1'b0));

      // two slots, zero scale: fill, failed steal, steal at equal priority, bad handle
      set_config(2, 0);
      send(pack_req(CMD_ALLOC, 10, 1'b0, 200, 50, 0, 1'b0));
      send(pack_req(CMD_ALLOC, 200, 1'b1, 100, 20, 0, 1'b0));
      send(pack_req(CMD_ALLOC, 5, 1'b0, 90, 90, 0, 1'b0));
      send(pack_req(CMD_ALLOC, 10, 1'b0, 127, 1, 0, 1'b0));
      send(pack_req(CMD_REMOVE, 0, 1'b0, 0, 0, 2, 1'b0));
      send(pack_req(CMD_REMOVE, 0, 1'b0, 0, 0, 1, 1'b0));

      // cached free slot left beyond a shrunken slot count
      set_config(32, 64);
      send(pack_req(CMD_FLUSH, 0, 1'b0, 0, 0, 0, 1'b0));
      send(pack_req(CMD_ALLOC, 20, 1'b0, 64, 63, 0, 1'b0));
      send(pack_req(CMD_ALLOC, 30, 1'b0, 126, 2, 0, 1'b0));
      set_config(2, 64);
      send(pack_req(CMD_ALLOC, 255, 1'b0, 255, 1, 0, 1'b0));

      // no slots at all
      set_config(0, 127);
      send(pack_req(CMD_ALLOC, 128, 1'b0, 10, 10, 0, 1'b0));
      send(pack_req(CMD_REMOVE, 0, 1'b0, 0, 0, 0, 1'b0));
      send(pack_req(CMD_FLUSH, 0, 1'b0, 0, 0, 0, 1'b0));

      // slot count above the table depth
      set_config(63, 127);
      send(pack_req(CMD_ALLOC, 128, 1'b1, 128, 127, 0, 1'b0));

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin seg_slots = 32; seg_scale = 127; end
            1: begin seg_slots = 1; seg_scale = 0; end
            2: begin seg_slots = 63; seg_scale = $urandom_range(1, 126); end
            3: begin seg_slots = 0; seg_scale = 127; end
            default: begin
               seg_slots = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                       : $urandom_range(1, 32);
               seg_scale = $urandom_range(0, 127);
            end
         endcase
         set_config(seg_slots, seg_scale);
         repeat (SEGMENT_ITEMS) send(random_req(live_count));
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin : receiver
      rx_mode_t mode;
      int       left;
      int       seen;
      int       pick;
      bit       squeezed;
      seen = 0;
      squeezed = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 9);
         left = $urandom_range(10, 150);
         if (pick < 4 || pick == 9) mode = RX_OPEN;
         else if (pick < 6) mode = RX_RANDOM;
         else if (pick == 6) mode = RX_TOGGLE;
         else if (pick == 7) mode = RX_SPARSE;
         else mode = RX_HOLD;
         // one long back-pressure stretch while the sender keeps offering
         if (!squeezed && seen >= 200) begin
            squeezed = 1'b1;
            mode = RX_HOLD;
            left = HOLD_OFF_CYCLES;
         end
         while (left > 0) begin
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
               RX_TOGGLE: rsp_ready <= left[0];
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= 1'b0;
            endcase
            @(posedge clock);
            if (rsp_valid && rsp_ready) seen++;
            left--;
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[filelist.f]
rtl/core/esa_pkg.sv
rtl/core/esa_table.sv
rtl/core/esa_vol.sv
rtl/core/emitter_slot_allocator.sv
tb/sv/esa_checker.sv
tb/sv/tb_emitter_slot_allocator.sv
